// ===== src/ppw_pkg.sv =====
// shared types and constants for the perspective projection warp block
`default_nettype none
package ppw_pkg;

  localparam int SCREEN_WIDTH_D  = 640;
  localparam int SCREEN_HEIGHT_D = 480;
  localparam int FRAC_BITS_D     = 16;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CAM_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WARP_X = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WARP_Y = 3'd6;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic               sat;
    logic               zero;
  } uv_t;

endpackage
`default_nettype wire

// ===== src/perspective_project_warp.sv =====
// perspective projection warp top level
// Projects one world point per clock to Q(32-FRAC_BITS).FRAC_BITS pixel coordinates. The
// pipeline takes a new item every cycle while out_stall is low; its depth is set by the two
// bit-per-stage dividers: 64 stages for the perspective divide and 2*FRAC_BITS+1 stages for
// the curve reciprocal. A stall on the output freezes the whole pipeline. Status 1 flags a zero
// depth difference (pixels read 0), status 2 flags saturation anywhere along the way.
`default_nettype none
module perspective_project_warp #(
  parameter int SCREEN_WIDTH  = ppw_pkg::SCREEN_WIDTH_D,
  parameter int SCREEN_HEIGHT = ppw_pkg::SCREEN_HEIGHT_D,
  parameter int FRAC_BITS     = ppw_pkg::FRAC_BITS_D
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [ppw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                    cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [31:0]             in_world_x,
  input  wire logic signed [31:0]             in_world_y,
  input  wire logic signed [31:0]             in_world_z,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [31:0]                  out_screen_x,
  output logic signed [31:0]                  out_screen_y,
  output logic [1:0]                          out_status
);

  localparam int RW = 2 * FRAC_BITS + 1;
  localparam int XW = FRAC_BITS + 3;
  localparam int TW = 35;
  localparam int UVW = $bits(ppw_pkg::uv_t);
  localparam logic [XW-1:0]       FIFTH  = XW'(((1 << FRAC_BITS) + 2) / 5);
  localparam logic [XW-1:0]       M10    = XW'((1 << XW) / 10);
  localparam logic [XW-1:0]       TEN_X  = XW'(10);
  localparam logic [TW-1:0]       TEN_T  = TW'(10);
  localparam logic [RW-1:0]       NUM_ONE = {1'b1, {(RW-1){1'b0}}};
  localparam logic signed [32:0]  HALF   = 33'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [14:0]  SCR_W  = 15'(SCREEN_WIDTH);
  localparam logic signed [14:0]  SCR_H  = 15'(SCREEN_HEIGHT);

  function automatic logic [32:0] fix_quo(input logic [63:0] q, input logic neg);
    logic        sat;
    logic [31:0] val;
    begin
      if (!neg) begin
        sat = (q > 64'h0000_0000_7FFF_FFFF);
        val = sat ? 32'h7FFF_FFFF : q[31:0];
      end else begin
        sat = (q > 64'h0000_0000_8000_0000);
        val = sat ? 32'h8000_0000 : (~q[31:0] + 32'd1);
      end
      fix_quo = {sat, val};
    end
  endfunction

  function automatic logic [32:0] clamp64(input logic signed [63:0] x);
    begin
      if (x > 64'sh0000_0000_7FFF_FFFF) begin
        clamp64 = {1'b1, 32'h7FFF_FFFF};
      end else if (x < -64'sh0000_0000_8000_0000) begin
        clamp64 = {1'b1, 32'h8000_0000};
      end else begin
        clamp64 = {1'b0, x[31:0]};
      end
    end
  endfunction

  // configuration registers
  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r, gain_x_r, gain_y_r, warp_x_r, warp_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r  <= '0;
      cam_y_r  <= '0;
      cam_z_r  <= '0;
      gain_x_r <= 32'sd1 <<< FRAC_BITS;
      gain_y_r <= 32'sd1 <<< FRAC_BITS;
      warp_x_r <= '0;
      warp_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ppw_pkg::CFG_CAM_X:  cam_x_r  <= cfg_data;
        ppw_pkg::CFG_CAM_Y:  cam_y_r  <= cfg_data;
        ppw_pkg::CFG_CAM_Z:  cam_z_r  <= cfg_data;
        ppw_pkg::CFG_GAIN_X: gain_x_r <= cfg_data;
        ppw_pkg::CFG_GAIN_Y: gain_y_r <= cfg_data;
        ppw_pkg::CFG_WARP_X: warp_x_r <= cfg_data;
        ppw_pkg::CFG_WARP_Y: warp_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // stage a: camera-relative coordinates
  logic               vld_a_r;
  logic signed [32:0] dx_a_r, dy_a_r, dz_a_r;

  // stage b: numerator products
  logic               vld_b_r;
  logic signed [63:0] pu_b_r, pv_b_r;
  logic signed [32:0] dz_b_r;
  logic signed [64:0] mu, mv;

  assign mu = dx_a_r * gain_x_r;
  assign mv = dy_a_r * gain_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_valid;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_a_r <= 33'(in_world_x) - 33'(cam_x_r);
      dy_a_r <= 33'(cam_y_r) - 33'(in_world_y);
      dz_a_r <= 33'(in_world_z) - 33'(cam_z_r);
      pu_b_r <= mu[63:0];
      pv_b_r <= mv[63:0];
      dz_b_r <= dz_a_r;
    end
  end

  // perspective divide, two lanes sharing the depth
  logic [63:0] num_u, num_v;
  logic [32:0] dz_abs;
  logic        vld_du, vld_dv;
  logic [63:0] qu, qv;
  logic [1:0]  side_u;
  logic        side_v;

  assign num_u  = pu_b_r[63] ? (~pu_b_r + 64'd1) : pu_b_r;
  assign num_v  = pv_b_r[63] ? (~pv_b_r + 64'd1) : pv_b_r;
  assign dz_abs = dz_b_r[32] ? (~dz_b_r + 33'd1) : dz_b_r;

  ppw_div #(.NW(64), .DW(32), .SW(2)) u_div_u (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vld_b_r), .in_num(num_u), .in_den(dz_abs[31:0]),
    .in_side({pu_b_r[63] ^ dz_b_r[32], dz_b_r == 33'sd0}),
    .out_valid(vld_du), .out_quo(qu), .out_side(side_u)
  );

  ppw_div #(.NW(64), .DW(32), .SW(1)) u_div_v (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vld_b_r), .in_num(num_v), .in_den(dz_abs[31:0]),
    .in_side(pv_b_r[63] ^ dz_b_r[32]),
    .out_valid(vld_dv), .out_quo(qv), .out_side(side_v)
  );

  // stage c: sign and clamp; stage d: curve divisor
  logic         vld_c_r, vld_d_r;
  ppw_pkg::uv_t uv_c_r, uv_d_r;
  logic [TW-1:0] t_d_r;
  logic         warp_d_r;
  logic [32:0]  fu, fv;

  assign fu = fix_quo(qu, side_u[1]);
  assign fv = fix_quo(qv, side_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
    end else if (en) begin
      vld_c_r <= vld_du;
      vld_d_r <= vld_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uv_c_r.u    <= fu[31:0];
      uv_c_r.v    <= fv[31:0];
      uv_c_r.sat  <= fu[32] | fv[32];
      uv_c_r.zero <= side_u[0];
      uv_d_r      <= uv_c_r;
      warp_d_r    <= !uv_c_r.v[31] && (uv_c_r.v != 32'sd0);
      t_d_r       <= TW'(uv_c_r.v[30:0]) * TEN_T + TW'(FIFTH);
    end
  end

  // curve reciprocal
  logic          vld_r2;
  logic [RW-1:0] r2;
  logic [UVW:0]  side_r2;
  ppw_pkg::uv_t  uv_r2;
  logic          warp_r2;

  ppw_div #(.NW(RW), .DW(TW), .SW(UVW + 1)) u_div_r (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(vld_d_r), .in_num(NUM_ONE), .in_den(t_d_r),
    .in_side({warp_d_r, uv_d_r}),
    .out_valid(vld_r2), .out_quo(r2), .out_side(side_r2)
  );

  assign warp_r2 = side_r2[UVW];
  assign uv_r2   = side_r2[UVW-1:0];

  // stages e..g: s = (r - fifth) / 10, stage h: warp products
  logic                        vld_e_r, vld_f_r, vld_g_r, vld_h_r;
  ppw_pkg::uv_t                uv_e_r, uv_f_r, uv_g_r, uv_h_r;
  logic [XW-1:0]               x_e_r, x_f_r;
  logic [2*XW-1:0]             prod_f_r;
  logic [FRAC_BITS-1:0]        s_g_r;
  logic signed [FRAC_BITS+32:0] pwx_h_r, pwy_h_r;
  logic [XW-1:0]               r_lo, q0, rm;

  assign r_lo = r2[XW-1:0];
  assign q0   = XW'(prod_f_r >> XW);
  assign rm   = x_f_r - XW'(q0 * TEN_X);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_e_r <= 1'b0;
      vld_f_r <= 1'b0;
      vld_g_r <= 1'b0;
      vld_h_r <= 1'b0;
    end else if (en) begin
      vld_e_r <= vld_r2;
      vld_f_r <= vld_e_r;
      vld_g_r <= vld_f_r;
      vld_h_r <= vld_g_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uv_e_r   <= uv_r2;
      x_e_r    <= (warp_r2 && (r_lo > FIFTH)) ? (r_lo - FIFTH) : '0;
      uv_f_r   <= uv_e_r;
      x_f_r    <= x_e_r;
      prod_f_r <= (2*XW)'(x_e_r) * (2*XW)'(M10);
      uv_g_r   <= uv_f_r;
      s_g_r    <= FRAC_BITS'((rm >= TEN_X) ? (q0 + XW'(1)) : q0);
      uv_h_r   <= uv_g_r;
      pwx_h_r  <= $signed({1'b0, s_g_r}) * warp_x_r;
      pwy_h_r  <= $signed({1'b0, s_g_r}) * warp_y_r;
    end
  end

  // stage i: apply warp; stage j: screen scaling
  logic               vld_i_r, vld_j_r;
  ppw_pkg::uv_t       uv_i_r;
  logic               sat_j_r, zero_j_r;
  logic signed [47:0] sx_j_r, sy_j_r;
  logic signed [63:0] wu, wv, shx, shy;
  logic [32:0]        cu, cv;
  logic signed [32:0] hu, hv;

  assign shx = pwx_h_r >>> FRAC_BITS;
  assign shy = pwy_h_r >>> FRAC_BITS;
  assign wu  = 64'(uv_h_r.u) + shx;
  assign wv  = 64'(uv_h_r.v) - shy;
  assign cu  = clamp64(wu);
  assign cv  = clamp64(wv);
  assign hu  = 33'(uv_i_r.u) + HALF;
  assign hv  = 33'(uv_i_r.v) + HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_i_r <= 1'b0;
      vld_j_r <= 1'b0;
    end else if (en) begin
      vld_i_r <= vld_h_r;
      vld_j_r <= vld_i_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uv_i_r.u    <= cu[31:0];
      uv_i_r.v    <= cv[31:0];
      uv_i_r.sat  <= uv_h_r.sat | cu[32] | cv[32];
      uv_i_r.zero <= uv_h_r.zero;
      sx_j_r      <= hu * SCR_W;
      sy_j_r      <= hv * SCR_H;
      sat_j_r     <= uv_i_r.sat;
      zero_j_r    <= uv_i_r.zero;
    end
  end

  // output register
  logic [32:0]        px, py;
  logic signed [31:0] screen_x_r, screen_y_r;
  logic [1:0]         status_r;

  assign px = clamp64(64'(sx_j_r));
  assign py = clamp64(64'(sy_j_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_j_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_j_r) begin
        screen_x_r <= '0;
        screen_y_r <= '0;
        status_r   <= ppw_pkg::ST_ZERO;
      end else begin
        screen_x_r <= px[31:0];
        screen_y_r <= py[31:0];
        status_r   <= (sat_j_r | px[32] | py[32]) ? ppw_pkg::ST_SAT : ppw_pkg::ST_OK;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_screen_x = screen_x_r;
  assign out_screen_y = screen_y_r;
  assign out_status   = status_r;

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    vld_du == vld_dv)
    else $error("divider lanes out of step");

  a_zero_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ppw_pkg::ST_ZERO |-> out_screen_x == 32'sd0 &&
    out_screen_y == 32'sd0)
    else $error("zero depth item with nonzero pixels");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !vld_a_r)
    else $error("pipeline not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule
`default_nettype wire

// ===== src/ppw_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with sideband
`default_nettype none
module ppw_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [NW-1:0]      out_quo,
  output logic [SW-1:0]      out_side
);

  logic          vld_r  [NW];
  logic [DW-1:0] rem_r  [NW];
  logic [NW-1:0] num_r  [NW];
  logic [NW-1:0] quo_r  [NW];
  logic [DW-1:0] den_r  [NW];
  logic [SW-1:0] side_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          p_vld;
    logic [DW-1:0] p_rem;
    logic [DW-1:0] p_den;
    logic [NW-1:0] p_num;
    logic [NW-1:0] p_quo;
    logic [SW-1:0] p_side;
    logic [DW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign p_vld  = in_valid;
      assign p_rem  = '0;
      assign p_den  = in_den;
      assign p_num  = in_num;
      assign p_quo  = '0;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld_r[k-1];
      assign p_rem  = rem_r[k-1];
      assign p_den  = den_r[k-1];
      assign p_num  = num_r[k-1];
      assign p_quo  = quo_r[k-1];
      assign p_side = side_r[k-1];
    end

    assign trial = {p_rem, p_num[NW-1]};
    assign take  = (trial >= {1'b0, p_den});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? DW'(trial - {1'b0, p_den}) : trial[DW-1:0];
        num_r[k]  <= p_num << 1;
        quo_r[k]  <= (p_quo << 1) | NW'(take);
        den_r[k]  <= p_den;
        side_r[k] <= p_side;
      end
    end
  end

  assign out_valid = vld_r[NW-1];
  assign out_quo   = quo_r[NW-1];
  assign out_side  = side_r[NW-1];

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking bench for the perspective projection warp block
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = ppw_pkg::FRAC_BITS_D;
  localparam int LATENCY = 76 + 2 * FB;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int NUM_RANDOM = 1200;
  localparam int NUM_DIRECTED = 16;

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    ppw_pkg::status_t st;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ppw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_world_x = '0, in_world_y = '0, in_world_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_screen_x, out_screen_y;
  logic [1:0] out_status;

  perspective_project_warp u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_world_x(in_world_x), .in_world_y(in_world_y), .in_world_z(in_world_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_screen_x(out_screen_x), .out_screen_y(out_screen_y), .out_status(out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  logic signed [31:0] camera [7];
  pixel_t pending_pixels [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  function automatic longint clamp_s32(longint x, ref bit sat);
    if (x > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic longint floor_shift(longint x);
    return x >>> FB;
  endfunction

  function automatic pixel_t project_point(logic signed [31:0] wx, logic signed [31:0] wy,
                                           logic signed [31:0] wz);
    longint dx, dy, dz, u, v, fifth, t, r, s;
    bit sat;
    pixel_t p;
    sat = 0;
    dx = longint'(wx) - longint'(camera[ppw_pkg::CFG_CAM_X]);
    dy = longint'(camera[ppw_pkg::CFG_CAM_Y]) - longint'(wy);
    dz = longint'(wz) - longint'(camera[ppw_pkg::CFG_CAM_Z]);
    if (dz == 0) begin
      p.sx = 0;
      p.sy = 0;
      p.st = ppw_pkg::ST_ZERO;
      return p;
    end
    u = clamp_s32((dx * longint'(camera[ppw_pkg::CFG_GAIN_X])) / dz, sat);
    v = clamp_s32((dy * longint'(camera[ppw_pkg::CFG_GAIN_Y])) / dz, sat);
    if (v > 0) begin
      fifth = ((64'sd1 <<< FB) + 2) / 5;
      t = 10 * v + fifth;
      r = (64'sd1 <<< (2 * FB)) / t;
      s = (r - fifth > 0) ? (r - fifth) / 10 : 0;
      u = clamp_s32(u + floor_shift(s * longint'(camera[ppw_pkg::CFG_WARP_X])), sat);
      v = clamp_s32(v - floor_shift(s * longint'(camera[ppw_pkg::CFG_WARP_Y])), sat);
    end
    u = u + (64'sd1 <<< (FB - 1));
    v = v + (64'sd1 <<< (FB - 1));
    p.sx = 32'(clamp_s32(u * ppw_pkg::SCREEN_WIDTH_D, sat));
    p.sy = 32'(clamp_s32(v * ppw_pkg::SCREEN_HEIGHT_D, sat));
    p.st = sat ? ppw_pkg::ST_SAT : ppw_pkg::ST_OK;
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch("unexpected item", out_screen_x, 0);
        end else begin
          want = pending_pixels.pop_front();
          if (out_screen_x !== want.sx) report_mismatch("screen_x", out_screen_x, want.sx);
          if (out_screen_y !== want.sy) report_mismatch("screen_y", out_screen_y, want.sy);
          if (out_status !== want.st) report_mismatch("status", out_status, want.st);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [ppw_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= ppw_pkg::CFG_WARP_Y) camera[idx] = val;
    @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz,
                            bit typed, pixel_t typed_pixel);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_world_x <= wx;
    in_world_y <= wy;
    in_world_z <= wz;
    pending_pixels.push_back(typed ? typed_pixel : project_point(wx, wy, wz));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] random_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 40 << FB)) - (20 << FB));
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2000 << FB)) - (1000 << FB));
    endcase
  endfunction

  task automatic random_phase(int count);
    logic [31:0] wz;
    repeat (count) begin
      wz = ($urandom_range(19) == 0) ? camera[ppw_pkg::CFG_CAM_Z] : random_coord();
      send_point(random_coord(), random_coord(), wz, 0, '{0, 0, ppw_pkg::ST_OK});
    end
    drain();
  endtask

  typedef struct {
    logic [31:0] wx, wy, wz;
    bit typed;
    pixel_t px;
  } directed_row_t;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{32'h0, 32'h0, 32'h0, 1, '{0, 0, ppw_pkg::ST_ZERO}},
    '{32'h0, 32'h0, 32'h0001_0000, 1, '{320 << 16, 240 << 16, ppw_pkg::ST_OK}},
    '{32'h7fffffff, 32'h0, 32'h1, 1, '{32'h7fffffff, 240 << 16, ppw_pkg::ST_SAT}},
    '{32'h80000000, 32'h0, 32'h1, 1, '{32'h80000000, 240 << 16, ppw_pkg::ST_SAT}},
    '{32'h0, 32'h80000000, 32'h1, 0, '{0, 0, ppw_pkg::ST_OK}},
    '{32'h0, 32'h7fffffff, 32'h1, 0, '{0, 0, ppw_pkg::ST_OK}},
    '{32'h0001_0000, 32'hffff_0000, 32'h0002_0000, 0, '{0, 0, ppw_pkg::ST_OK}},
    '{32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 0, '{0, 0, ppw_pkg::ST_OK}},
    '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, '{0, 0, ppw_pkg::ST_OK}},
    '{32'h0, 32'hfff0_0000, 32'h0000_4000, 0, '{0, 0, ppw_pkg::ST_OK}},
    '{32'h0, 32'h0, 32'h80000000, 0, '{0, 0, ppw_pkg::ST_OK}},
    '{32'h0, 32'h0, 32'h7fffffff, 0, '{0, 0, ppw_pkg::ST_OK}},
    '{32'h5555_5555, 32'haaaa_aaaa, 32'h0100_0000, 0, '{0, 0, ppw_pkg::ST_OK}},
    '{32'haaaa_aaaa, 32'h5555_5555, 32'hff00_0000, 0, '{0, 0, ppw_pkg::ST_OK}},
    '{32'h0, 32'hffff_fff0, 32'h0000_0100, 0, '{0, 0, ppw_pkg::ST_OK}},
    '{32'h0, 32'h0000_0010, 32'h0000_0100, 0, '{0, 0, ppw_pkg::ST_OK}}
  };

  initial begin
    camera = '{0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_point(directed_rows[i].wx, directed_rows[i].wy, directed_rows[i].wz,
                 directed_rows[i].typed, directed_rows[i].px);
    drain();

    // warp on, camera moved, plus an index past the last register
    write_reg(ppw_pkg::CFG_CAM_X, 32'h0002_0000);
    write_reg(ppw_pkg::CFG_CAM_Y, 32'h0001_8000);
    write_reg(ppw_pkg::CFG_CAM_Z, 32'hfffc_0000);
    write_reg(ppw_pkg::CFG_GAIN_X, 32'h0003_0000);
    write_reg(ppw_pkg::CFG_GAIN_Y, 32'h0002_0000);
    write_reg(ppw_pkg::CFG_WARP_X, 32'h0040_0000);
    write_reg(ppw_pkg::CFG_WARP_Y, 32'hffc0_0000);
    write_reg(3'd7, 32'hdead_beef);
    send_idle_pct = 17;
    recv_idle_pct = 70;
    random_phase(NUM_RANDOM / 3);

    write_reg(ppw_pkg::CFG_CAM_X, 32'h7fffffff);
    write_reg(ppw_pkg::CFG_CAM_Y, 32'h80000000);
    write_reg(ppw_pkg::CFG_CAM_Z, 32'h7fffffff);
    write_reg(ppw_pkg::CFG_GAIN_X, 32'h80000000);
    write_reg(ppw_pkg::CFG_GAIN_Y, 32'h7fffffff);
    write_reg(ppw_pkg::CFG_WARP_X, 32'h7fffffff);
    write_reg(ppw_pkg::CFG_WARP_Y, 32'h80000000);
    send_idle_pct = 70;
    recv_idle_pct = 17;
    random_phase(NUM_RANDOM / 3);

    for (int r = 0; r <= ppw_pkg::CFG_WARP_Y; r++)
      write_reg(r[ppw_pkg::CFG_IDX_W-1:0], $urandom());
    write_reg(ppw_pkg::CFG_CAM_Z, 32'h0);
    write_reg(ppw_pkg::CFG_GAIN_Y, 32'h0001_0000 + $urandom_range(0, 32'h0010_0000));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(NUM_RANDOM / 3);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
